@@ design/lbmk_pkg.sv @@
// shared types, constants and morse code tables for the led blink and morse keyer
// no dependencies; imported by lbmk_step, led_blink_and_morse_keyer_core and the testbench
`default_nettype none

package lbmk_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned DOT_W      = 7;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned POS_W      = 3;

  localparam logic [DOT_W-1:0] DOT_RESET = 7'd50;
  localparam logic [7:0]       CHAR_A    = 8'h41;
  localparam logic [7:0]       CHAR_Z    = 8'h5a;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLINK_ENABLE = 3'd0,
    REG_ON_TIME      = 3'd1,
    REG_PERIOD       = 3'd2,
    REG_ACTIVE_LOW   = 3'd3,
    REG_DOT_TICKS    = 3'd4
  } lbmk_reg_e;

  typedef struct packed {
    logic             blink_enable;
    logic [CNT_W-1:0] on_time;
    logic [CNT_W-1:0] period;
    logic             active_low;
    logic [DOT_W-1:0] dot_ticks;
  } lbmk_cfg_t;

  typedef struct packed {
    logic             busy_flag;
    logic [CNT_W-1:0] tick_counter;
    logic             in_gap;
    logic             end_pending;
    logic [IDX_W-1:0] letter_index;
    logic [POS_W-1:0] element_pos;
    logic             pin_state;
  } lbmk_state_t;

  // number of elements in the letter
  function automatic logic [POS_W-1:0] code_len(input logic [IDX_W-1:0] idx);
    logic [POS_W-1:0] len;
    case (idx)
      5'd0:  len = 3'd2;
      5'd1:  len = 3'd4;
      5'd2:  len = 3'd4;
      5'd3:  len = 3'd3;
      5'd4:  len = 3'd1;
      5'd5:  len = 3'd4;
      5'd6:  len = 3'd3;
      5'd7:  len = 3'd4;
      5'd8:  len = 3'd2;
      5'd9:  len = 3'd4;
      5'd10: len = 3'd3;
      5'd11: len = 3'd4;
      5'd12: len = 3'd2;
      5'd13: len = 3'd2;
      5'd14: len = 3'd3;
      5'd15: len = 3'd4;
      5'd16: len = 3'd4;
      5'd17: len = 3'd3;
      5'd18: len = 3'd3;
      5'd19: len = 3'd1;
      5'd20: len = 3'd3;
      5'd21: len = 3'd4;
      5'd22: len = 3'd3;
      5'd23: len = 3'd4;
      5'd24: len = 3'd4;
      5'd25: len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // element k in bit k, 1 is a dash
  function automatic logic [7:0] code_pat(input logic [IDX_W-1:0] idx);
    logic [7:0] pat;
    case (idx)
      5'd0:  pat = 8'd2;
      5'd1:  pat = 8'd1;
      5'd2:  pat = 8'd5;
      5'd3:  pat = 8'd1;
      5'd4:  pat = 8'd0;
      5'd5:  pat = 8'd4;
      5'd6:  pat = 8'd3;
      5'd7:  pat = 8'd0;
      5'd8:  pat = 8'd0;
      5'd9:  pat = 8'd14;
      5'd10: pat = 8'd5;
      5'd11: pat = 8'd2;
      5'd12: pat = 8'd3;
      5'd13: pat = 8'd1;
      5'd14: pat = 8'd7;
      5'd15: pat = 8'd6;
      5'd16: pat = 8'd11;
      5'd17: pat = 8'd2;
      5'd18: pat = 8'd0;
      5'd19: pat = 8'd1;
      5'd20: pat = 8'd4;
      5'd21: pat = 8'd8;
      5'd22: pat = 8'd6;
      5'd23: pat = 8'd9;
      5'd24: pat = 8'd13;
      5'd25: pat = 8'd3;
      default: pat = 8'd0;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

@@ design/lbmk_step.sv @@
// next-state logic for one word: idle blink, letter start and morse tick
// depends on lbmk_pkg
`default_nettype none

module lbmk_step import lbmk_pkg::*; (
  input  wire lbmk_state_t      state_i,
  input  wire lbmk_cfg_t        cfg_i,
  input  wire                   cmd_i,
  input  wire [7:0]             letter_i,
  output lbmk_state_t           state_o,
  output logic                  rejected_o
);

  logic             lit;
  logic             dark;
  logic [CNT_W-1:0] dot8;
  logic [CNT_W-1:0] two_dot;
  logic [CNT_W-1:0] three_dot;
  logic             letter_ok;
  logic [7:0]       letter_off;

  assign lit        = ~cfg_i.active_low;
  assign dark       = cfg_i.active_low;
  assign dot8       = {1'b0, cfg_i.dot_ticks};
  assign two_dot    = {cfg_i.dot_ticks, 1'b0};
  assign three_dot  = dot8 + two_dot;
  assign letter_ok  = (letter_i >= CHAR_A) && (letter_i <= CHAR_Z);
  assign letter_off = letter_i - CHAR_A;

  always_comb begin
    lbmk_state_t      s;
    logic [POS_W-1:0] len;
    logic [7:0]       pat;
    logic [CNT_W-1:0] cnt;
    logic             run_morse;

    s          = state_i;
    rejected_o = 1'b0;
    run_morse  = 1'b0;

    if (state_i.busy_flag) begin
      run_morse = 1'b1;
    end else if (cmd_i) begin
      if (letter_ok) begin
        // start a letter: the counter is set so that this word's morse tick lands on the first element
        s.letter_index = letter_off[IDX_W-1:0];
        s.element_pos  = '0;
        s.tick_counter = 8'd1;
        s.busy_flag    = 1'b1;
        s.in_gap       = 1'b1;
        run_morse      = 1'b1;
      end else begin
        rejected_o = 1'b1;
      end
    end else if (!cfg_i.blink_enable) begin
      s.pin_state = lit;
    end else begin
      cnt            = state_i.tick_counter - 8'd1;
      s.tick_counter = cnt;
      if (cnt == '0) begin
        s.pin_state    = dark;
        s.tick_counter = cfg_i.period;
      end else if (cnt == cfg_i.on_time) begin
        s.pin_state = lit;
      end
    end

    len = code_len(s.letter_index);
    pat = code_pat(s.letter_index);
    cnt = s.tick_counter - 8'd1;

    if (run_morse) begin
      s.tick_counter = cnt;
      if (cnt == '0) begin
        if (!s.in_gap) begin
          s.pin_state    = dark;
          s.in_gap       = 1'b1;
          s.tick_counter = dot8;
        end else if (s.element_pos < len) begin
          s.pin_state    = lit;
          s.tick_counter = pat[s.element_pos] ? three_dot : dot8;
          s.element_pos  = s.element_pos + 3'd1;
          s.in_gap       = 1'b0;
          s.end_pending  = 1'b0;
        end else if (s.end_pending) begin
          s.busy_flag = 1'b0;
        end else begin
          s.tick_counter = two_dot;
          s.end_pending  = 1'b1;
        end
      end
    end

    state_o = s;
  end

endmodule

`default_nettype wire

@@ design/led_blink_and_morse_keyer_core.sv @@
// top level of the led blink and morse keyer: handshakes, config registers, state
// depends on lbmk_pkg and lbmk_step
`default_nettype none

// channel   signals                                   direction
// in        in_valid_i in_ready_o cmd_i letter_i      word in
// out       out_valid_o out_ready_i pin_level_o
//           busy_res_o rejected_o                     word out
// cfg       cfg_valid_i cfg_ready_o cfg_index_i
//           cfg_data_i                                register write
//
// one word per cycle sustained while the result side is not stalled; a word is
// taken into the input register, then steps into the result register when the
// result slot is free, and the keyer state is updated in that step as well
// reset clears the state, the pipeline valids and the config to its defaults
// a stalled result holds only the result register; the input register still
// takes one word, then in_ready_o drops until the result moves on

module led_blink_and_morse_keyer_core import lbmk_pkg::*; (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire                   cmd_i,
  input  wire [7:0]             letter_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic                  pin_level_o,
  output logic                  busy_res_o,
  output logic                  rejected_o,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [CFG_DATA_W-1:0]  cfg_data_i
);

  lbmk_cfg_t   cfg_q;
  lbmk_state_t state_q, state_d;

  logic        in_vld_q;
  logic        cmd_q;
  logic [7:0]  letter_q;
  logic        step_fire;
  logic        rejected_d;

  logic        out_vld_q;
  logic        pin_q;
  logic        busy_q;
  logic        rej_q;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_enable <= 1'b0;
      cfg_q.on_time      <= '0;
      cfg_q.period       <= '0;
      cfg_q.active_low   <= 1'b0;
      cfg_q.dot_ticks    <= DOT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BLINK_ENABLE: cfg_q.blink_enable <= cfg_data_i[0];
        REG_ON_TIME:      cfg_q.on_time      <= cfg_data_i;
        REG_PERIOD:       cfg_q.period       <= cfg_data_i;
        REG_ACTIVE_LOW:   cfg_q.active_low   <= cfg_data_i[0];
        REG_DOT_TICKS:    cfg_q.dot_ticks    <= cfg_data_i[DOT_W-1:0];
        default: ;
      endcase
    end
  end

  // the word in the input register moves on when the result slot frees up
  assign step_fire  = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q    <= cmd_i;
      letter_q <= letter_i;
    end
  end

  lbmk_step u_step (
    .state_i    (state_q),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd_q),
    .letter_i   (letter_q),
    .state_o    (state_d),
    .rejected_o (rejected_d)
  );

  // keyer state advances once per word, together with its result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      pin_q  <= state_d.pin_state;
      busy_q <= state_d.busy_flag;
      rej_q  <= rejected_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign pin_level_o = pin_q;
  assign busy_res_o  = busy_q;
  assign rejected_o  = rej_q;

endmodule

`default_nettype wire

@@ tb/led_blink_and_morse_keyer_core_tb.sv @@
// self-checking testbench for led_blink_and_morse_keyer_core: directed table, then random phases
// depends on lbmk_pkg (register indexes, widths, letter bounds) and the core itself
`timescale 1ns / 100ps

module led_blink_and_morse_keyer_core_tb;
  import lbmk_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 400_000;
  localparam int unsigned WORD_TARGET     = 1400;
  localparam int unsigned CALM_FROM       = 1200;

  // what a word asks of the keyer
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef struct packed {
    logic pin;
    logic busy;
    logic rej;
  } led_word_t;

  // results that can be read straight off the idle behavior
  localparam led_word_t IDLE_HIGH = 3'b100;
  localparam led_word_t REJ_HIGH  = 3'b101;
  localparam led_word_t IDLE_LOW  = 3'b000;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  // one line of the directed table: a word (a = cmd, b = letter) sent reps times,
  // or a register write (a = index, b = data)
  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] a;
    logic [7:0] b;
    logic [4:0] reps;
    logic       typed;
    led_word_t  want;
  } plan_row_t;

  // dut connections
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  cmd = CMD_TICK;
  logic [7:0]            letter = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic                  pin_level;
  logic                  busy_res;
  logic                  rejected;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // keyer model: register copies
  logic             blink_on;
  logic [7:0]       on_point;
  logic [7:0]       reload;
  logic             lit_low;
  logic [DOT_W-1:0] dot_len;

  // keyer model: running state
  logic       sending;
  logic [7:0] ticks_left;
  logic       in_space;
  logic       closing;
  logic [7:0] cur_char;
  logic [2:0] elems_done;
  logic       pin_now;

  led_word_t led_words_due[$];
  plan_row_t plan[$];
  int        errors = 0;
  int        words_sent = 0;
  int        cycles = 0;
  bit        quiet = 1'b0;  // no idling on either side from here on
  bit        calm = 1'b0;   // no idling during this phase
  int        hold_left = 0;

  led_blink_and_morse_keyer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (cmd),
    .letter_i    (letter),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .pin_level_o (pin_level),
    .busy_res_o  (busy_res),
    .rejected_o  (rejected),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  // morse spelled out as dots and dashes, first element first
  function automatic string morse_of(input logic [7:0] c);
    case (c)
      "A": return ".-";
      "B": return "-...";
      "C": return "-.-.";
      "D": return "-..";
      "E": return ".";
      "F": return "..-.";
      "G": return "--.";
      "H": return "....";
      "I": return "..";
      "J": return ".---";
      "K": return "-.-";
      "L": return ".-..";
      "M": return "--";
      "N": return "-.";
      "O": return "---";
      "P": return ".--.";
      "Q": return "--.-";
      "R": return ".-.";
      "S": return "...";
      "T": return "-";
      "U": return "..-";
      "V": return "...-";
      "W": return ".--";
      "X": return "-..-";
      "Y": return "-.--";
      "Z": return "--..";
      default: return "";
    endcase
  endfunction

  function automatic void keyer_reset();
    blink_on   = 1'b0;
    on_point   = 8'd0;
    reload     = 8'd0;
    lit_low    = 1'b0;
    dot_len    = DOT_RESET;
    sending    = 1'b0;
    ticks_left = 8'd0;
    in_space   = 1'b0;
    closing    = 1'b0;
    cur_char   = 8'd0;
    elems_done = 3'd0;
    pin_now    = 1'b0;
  endfunction

  function automatic void note_reg(input lbmk_reg_e r, input logic [7:0] d);
    case (r)
      REG_BLINK_ENABLE: blink_on = d[0];
      REG_ON_TIME:      on_point = d;
      REG_PERIOD:       reload = d;
      REG_ACTIVE_LOW:   lit_low = d[0];
      REG_DOT_TICKS:    dot_len = d[DOT_W-1:0];
      default: ;
    endcase
  endfunction

  // one tick of the letter being keyed; the dark level equals lit_low
  function automatic void morse_tick();
    string      code;
    logic [7:0] unit;
    code = morse_of(cur_char);
    unit = {1'b0, dot_len};
    ticks_left = ticks_left - 8'd1;
    if (ticks_left != 8'd0) return;
    if (!in_space) begin
      pin_now    = lit_low;
      in_space   = 1'b1;
      ticks_left = unit;
    end else if (int'(elems_done) < code.len()) begin
      pin_now    = !lit_low;
      // dash is three units, truncated to the counter width
      ticks_left = (code[elems_done] == "-") ? unit * 8'd3 : unit;
      elems_done = elems_done + 3'd1;
      in_space   = 1'b0;
      closing    = 1'b0;
    end else if (closing) begin
      sending = 1'b0;
    end else begin
      // two more units close the letter
      ticks_left = unit << 1;
      closing    = 1'b1;
    end
  endfunction

  function automatic void blink_tick();
    if (!blink_on) begin
      pin_now = !lit_low;
      return;
    end
    ticks_left = ticks_left - 8'd1;
    if (ticks_left == 8'd0) begin
      pin_now    = lit_low;
      ticks_left = reload;
    end else if (ticks_left == on_point) begin
      pin_now = !lit_low;
    end
  endfunction

  function automatic led_word_t keyer_step(input logic c, input logic [7:0] ch);
    logic rej;
    rej = 1'b0;
    if (sending) begin
      morse_tick();
    end else if (c == CMD_START) begin
      if (ch >= CHAR_A && ch <= CHAR_Z) begin
        cur_char   = ch;
        elems_done = 3'd0;
        ticks_left = 8'd1;
        sending    = 1'b1;
        in_space   = 1'b1;
        morse_tick();
      end else begin
        rej = 1'b1;
      end
    end else begin
      blink_tick();
    end
    return {pin_now, sending, rej};
  endfunction

  function automatic plan_row_t row_of(input row_kind_e k, input logic [7:0] a,
                                       input logic [7:0] b, input logic [4:0] reps,
                                       input logic typed, input led_word_t want);
    plan_row_t p;
    p.kind  = k;
    p.a     = a;
    p.b     = b;
    p.reps  = reps;
    p.typed = typed;
    p.want  = want;
    return p;
  endfunction

  // offer one word, at times with a random gap in front (never while quiet or calm), and queue its expected result
  task automatic send_word(input logic c, input logic [7:0] ch, input logic typed,
                           input led_word_t want);
    led_word_t due;
    if (cfg_valid) cfg_valid <= 1'b0;
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    letter   <= ch;
    do @(posedge clk); while (!in_ready);
    due = keyer_step(c, ch);
    led_words_due.push_back(typed ? want : due);
    words_sent++;
  endtask

  // config write; cfg_valid is left high for a following write and lowered by the next word
  task automatic write_reg(input lbmk_reg_e r, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    note_reg(r, d);
  endtask

  // stop offering words and wait until every expected word has come back
  task automatic drain_words();
    if (in_valid) in_valid <= 1'b0;
    while (led_words_due.size() != 0) @(posedge clk);
  endtask

  // result side: random stall bursts, none while calm or quiet
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= (hold_left == 1);
    end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      hold_left <= $urandom_range(1, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare every accepted result word with the oldest expectation
  always @(posedge clk) begin
    led_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (led_words_due.size() == 0) begin
        $error("unexpected result word: pin_level %0b busy_res %0b rejected %0b",
               pin_level, busy_res, rejected);
        errors++;
      end else begin
        want = led_words_due.pop_front();
        if (pin_level !== want.pin) begin
          $error("pin_level mismatch: expected %0b, got %0b", want.pin, pin_level);
          errors++;
        end
        if (busy_res !== want.busy) begin
          $error("busy_res mismatch: expected %0b, got %0b", want.busy, busy_res);
          errors++;
        end
        if (rejected !== want.rej) begin
          $error("rejected mismatch: expected %0b, got %0b", want.rej, rejected);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > WATCHDOG_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int         phase;
    int         quota;
    int         n;
    int         r;
    bit         blinky;
    logic       c;
    logic [7:0] ch;
    logic [7:0] per;
    logic [7:0] on;
    logic [7:0] dot;

    keyer_reset();

    // directed table, starting from the reset defaults (steady on, active high, dot 50)
    // a tick, then bad letters while idle: below, above and just outside A-Z, all rejected
    plan.push_back(row_of(ROW_WORD, 8'(CMD_TICK),  8'h00, 5'd1, 1'b1, IDLE_HIGH));
    plan.push_back(row_of(ROW_WORD, 8'(CMD_START), 8'h00, 5'd1, 1'b1, REJ_HIGH));
    plan.push_back(row_of(ROW_WORD, 8'(CMD_START), 8'hff, 5'd1, 1'b1, REJ_HIGH));
    plan.push_back(row_of(ROW_WORD, 8'(CMD_START), "@",   5'd1, 1'b1, REJ_HIGH));
    plan.push_back(row_of(ROW_WORD, 8'(CMD_START), "[",   5'd1, 1'b1, REJ_HIGH));
    // shortest dot; key Z, with a start for A while busy that counts as a tick
    plan.push_back(row_of(ROW_REG,  8'(REG_DOT_TICKS), 8'd1, 5'd1, 1'b0, IDLE_LOW));
    plan.push_back(row_of(ROW_WORD, 8'(CMD_START), "Z",   5'd1, 1'b0, IDLE_LOW));
    plan.push_back(row_of(ROW_WORD, 8'(CMD_START), "A",   5'd1, 1'b0, IDLE_LOW));
    plan.push_back(row_of(ROW_WORD, 8'(CMD_TICK),  8'h00, 5'd13, 1'b0, IDLE_LOW));
    // reversed wiring: steady on now drives the pin low
    plan.push_back(row_of(ROW_REG,  8'(REG_ACTIVE_LOW), 8'd1, 5'd1, 1'b0, IDLE_LOW));
    plan.push_back(row_of(ROW_WORD, 8'(CMD_TICK),  8'h5a, 5'd1, 1'b1, IDLE_LOW));
    // blink with on point 255, period 0: counter wraps from zero to the on point
    plan.push_back(row_of(ROW_REG,  8'(REG_BLINK_ENABLE), 8'd1,   5'd1, 1'b0, IDLE_LOW));
    plan.push_back(row_of(ROW_REG,  8'(REG_ON_TIME),      8'd255, 5'd1, 1'b0, IDLE_LOW));
    plan.push_back(row_of(ROW_REG,  8'(REG_PERIOD),       8'd0,   5'd1, 1'b0, IDLE_LOW));
    plan.push_back(row_of(ROW_WORD, 8'(CMD_TICK),  8'h00, 5'd1, 1'b0, IDLE_LOW));
    // polarity flip leaves the pin where it is until it is next driven
    plan.push_back(row_of(ROW_REG,  8'(REG_ACTIVE_LOW), 8'd0, 5'd1, 1'b0, IDLE_LOW));
    plan.push_back(row_of(ROW_WORD, 8'(CMD_TICK),  8'h00, 5'd1, 1'b0, IDLE_LOW));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain_words();
        write_reg(lbmk_reg_e'(plan[i].a[CFG_IDX_W-1:0]), plan[i].b);
      end else begin
        repeat (plan[i].reps) send_word(plan[i].a[0], plan[i].b, plan[i].typed, plan[i].want);
      end
    end

    // random phases: phase 0 keys E at the longest dot, every fourth phase
    // blinks, the rest mostly key letters at short dot times
    phase = 0;
    while (words_sent < WORD_TARGET) begin
      drain_words();
      calm   = ($urandom_range(0, 4) == 0);
      blinky = (phase % 4 == 1);

      if (phase == 0) dot = 8'd85;
      else if ($urandom_range(0, 7) == 0) dot = 8'($urandom_range(1, 12));
      else dot = 8'($urandom_range(1, 4));

      r = $urandom_range(0, 9);
      if (phase == 1 || r == 0) per = 8'd0;
      else if (r == 1) per = 8'd255;
      else if (blinky) per = 8'($urandom_range(1, 20));
      else per = 8'($urandom_range(0, 255));

      r = $urandom_range(0, 9);
      if (r == 0) on = 8'd0;
      else if (r == 1) on = 8'd255;
      else on = 8'($urandom_range(0, per));

      write_reg(REG_BLINK_ENABLE, blinky ? 8'd1 : 8'($urandom_range(0, 1)));
      write_reg(REG_ON_TIME, on);
      write_reg(REG_PERIOD, per);
      write_reg(REG_ACTIVE_LOW, 8'($urandom_range(0, 1)));
      write_reg(REG_DOT_TICKS, dot);

      quota = (phase == 0) ? 1 : (blinky ? 300 : 60);
      n = 0;
      // a letter in progress is always finished before the phase ends
      while (n < quota || sending) begin
        if (sending) begin
          c  = 1'($urandom_range(0, 1));
          ch = 8'($urandom_range(0, 255));
        end else if (phase == 0) begin
          c  = CMD_START;
          ch = "E";
        end else begin
          r = $urandom_range(0, 9);
          if (r < (blinky ? 1 : 5)) begin
            c  = CMD_START;
            ch = 8'($urandom_range(CHAR_A, CHAR_Z));
          end else if (r < (blinky ? 2 : 7)) begin
            // bad letter: anything outside A-Z
            c  = CMD_START;
            ch = 8'($urandom_range(0, 255));
            if (ch >= CHAR_A && ch <= CHAR_Z) ch = ch ^ 8'h80;
          end else begin
            c  = CMD_TICK;
            ch = 8'($urandom_range(0, 255));
          end
        end
        send_word(c, ch, 1'b0, IDLE_LOW);
        n++;
      end
      quiet = (words_sent >= CALM_FROM);
      phase++;
    end

    drain_words();
    if (cfg_valid) cfg_valid <= 1'b0;
    // let any stray word show up
    repeat (8) @(posedge clk);

    if (errors == 0 && led_words_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
